/* rtl/dcd_pkg.sv */
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared types and constants of the directed cycle detector: controller
// states, the command and status groups between controller and datapath,
// and the register map of the configuration port.
// ----------------------------------------------------------------------------
package dcd_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned NODE_COUNT_W = 7;
  localparam int unsigned NODE_FIELD_W = 6;

  localparam logic [PADDR_W-1:0] REG_NODE_COUNT = 3'd0;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_SEARCH_INIT,
    ST_START,
    ST_ROW_RD,
    ST_STEP,
    ST_POP_RD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic write_row;
    logic search_init;
    logic start_inc;
    logic push_start;
    logic load_row;
    logic cursor_inc;
    logic push_nbr;
    logic pop;
    logic load_top;
    logic found;
    logic finish;
  } dcd_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic in_last;
    logic last_q;
    logic start_done;
    logic start_visited;
    logic cur_done;
    logic cur_edge;
    logic cur_on_path;
    logic cur_visited;
    logic depth_one;
    logic out_busy;
  } dcd_sts_t;

endpackage

/* rtl/dcd_ram.sv */
// ----------------------------------------------------------------------------
// dcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dcd_ctrl.sv */
// ----------------------------------------------------------------------------
// dcd_ctrl
// Controller of the cycle detector: sequences edge loading, the iterative
// depth-first search and the hand-off of the result.
// ----------------------------------------------------------------------------
module dcd_ctrl
  import dcd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dcd_sts_t sts_i,
  output dcd_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.edge_ok) begin
            state_d = ST_LOAD_WR;
          end else if (sts_i.in_last) begin
            state_d = ST_SEARCH_INIT;
          end
        end
      end
      ST_LOAD_WR: begin
        cmd_o.write_row = 1'b1;
        state_d = sts_i.last_q ? ST_SEARCH_INIT : ST_IDLE;
      end
      ST_SEARCH_INIT: begin
        cmd_o.search_init = 1'b1;
        state_d = ST_START;
      end
      ST_START: begin
        if (sts_i.start_done) begin
          state_d = ST_DONE;
        end else if (sts_i.start_visited) begin
          cmd_o.start_inc = 1'b1;
        end else begin
          cmd_o.push_start = 1'b1;
          state_d = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        cmd_o.load_row = 1'b1;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (sts_i.cur_done) begin
          cmd_o.pop = 1'b1;
          if (sts_i.depth_one) begin
            cmd_o.start_inc = 1'b1;
            state_d = ST_START;
          end else begin
            state_d = ST_POP_RD;
          end
        end else if (sts_i.cur_edge && sts_i.cur_on_path) begin
          cmd_o.found = 1'b1;
          state_d = ST_DONE;
        end else if (sts_i.cur_edge && !sts_i.cur_visited) begin
          cmd_o.push_nbr = 1'b1;
          state_d = ST_ROW_RD;
        end else begin
          cmd_o.cursor_inc = 1'b1;
        end
      end
      ST_POP_RD: begin
        cmd_o.load_top = 1'b1;
        state_d = ST_ROW_RD;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dcd_datapath.sv */
// ----------------------------------------------------------------------------
// dcd_datapath
// Datapath of the cycle detector: adjacency row memory with row valid bits,
// path stack memory, visited and on-path marks, search counters and the
// result register.
// ----------------------------------------------------------------------------
module dcd_datapath
  import dcd_pkg::*;
#(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [NODE_COUNT_W-1:0] node_count_i,
  input  logic [NODE_FIELD_W-1:0] src_node_i,
  input  logic [NODE_FIELD_W-1:0] dst_node_i,
  input  logic                    edge_present_i,
  input  logic                    last_edge_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    has_cycle_o,
  output logic                    bad_edge_seen_o,
  input  dcd_cmd_t                cmd_i,
  output dcd_sts_t                sts_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned SW = AW + CW;

  logic [CW-1:0]        n_eff;
  logic                 in_range;

  logic [AW-1:0]        src_q;
  logic [AW-1:0]        dst_q;
  logic                 last_q;
  logic [MAX_NODES-1:0] row_valid_q;
  logic                 bad_q;
  logic [MAX_NODES-1:0] visited_q;
  logic [MAX_NODES-1:0] on_path_q;
  logic [CW-1:0]        start_q;
  logic [CW-1:0]        depth_q;
  logic [AW-1:0]        top_q;
  logic [CW-1:0]        cursor_q;
  logic [MAX_NODES-1:0] row_q;
  logic                 cycle_q;
  logic                 out_valid_q;
  logic                 has_cycle_q;
  logic                 bad_out_q;

  logic [AW-1:0]        cur_idx;
  logic [AW-1:0]        start_idx;
  logic [AW-1:0]        adj_raddr;
  logic [MAX_NODES-1:0] adj_rdata;
  logic [MAX_NODES-1:0] adj_wdata;
  logic [MAX_NODES-1:0] dst_bit;
  logic [SW-1:0]        stk_wdata;
  logic [SW-1:0]        stk_rdata;
  logic [AW-1:0]        stk_waddr;
  logic [AW-1:0]        stk_raddr;
  logic [AW-1:0]        stk_node;
  logic [CW-1:0]        stk_cursor;

  assign n_eff = (int'(node_count_i) > int'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_i);
  assign in_range = (int'(src_node_i) < int'(n_eff)) && (int'(dst_node_i) < int'(n_eff));

  assign cur_idx   = AW'(cursor_q);
  assign start_idx = AW'(start_q);
  assign stk_node   = stk_rdata[SW-1:CW];
  assign stk_cursor = stk_rdata[CW-1:0];

  always_comb begin
    if (cmd_i.push_start) begin
      adj_raddr = start_idx;
    end else if (cmd_i.push_nbr) begin
      adj_raddr = cur_idx;
    end else if (cmd_i.load_top) begin
      adj_raddr = stk_node;
    end else begin
      adj_raddr = AW'(src_node_i);
    end
  end

  always_comb begin
    dst_bit = '0;
    dst_bit[dst_q] = 1'b1;
  end

  assign adj_wdata = (row_valid_q[src_q] ? adj_rdata : '0) | dst_bit;

  dcd_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_row),
    .waddr_i (src_q),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  assign stk_waddr = AW'(depth_q - CW'(1));
  assign stk_raddr = AW'(depth_q - CW'(2));
  assign stk_wdata = {top_q, cursor_q + CW'(1)};

  dcd_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_NODES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_nbr),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      src_q <= AW'(src_node_i);
      dst_q <= AW'(dst_node_i);
    end
    if (cmd_i.push_start) begin
      top_q    <= start_idx;
      cursor_q <= '0;
    end else if (cmd_i.push_nbr) begin
      top_q    <= cur_idx;
      cursor_q <= '0;
    end else if (cmd_i.load_top) begin
      top_q    <= stk_node;
      cursor_q <= stk_cursor;
    end else if (cmd_i.cursor_inc) begin
      cursor_q <= cursor_q + CW'(1);
    end
    if (cmd_i.load_row) begin
      row_q <= row_valid_q[top_q] ? adj_rdata : '0;
    end
    if (cmd_i.finish) begin
      has_cycle_q <= cycle_q;
      bad_out_q   <= bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      row_valid_q <= '0;
      bad_q       <= 1'b0;
      visited_q   <= '0;
      on_path_q   <= '0;
      start_q     <= '0;
      depth_q     <= '0;
      cycle_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= last_edge_i;
        if (edge_present_i && !in_range) begin
          bad_q <= 1'b1;
        end
      end
      if (cmd_i.write_row) begin
        row_valid_q[src_q] <= 1'b1;
      end
      if (cmd_i.search_init) begin
        visited_q <= '0;
        on_path_q <= '0;
        start_q   <= '0;
        depth_q   <= '0;
        cycle_q   <= 1'b0;
      end
      if (cmd_i.start_inc) begin
        start_q <= start_q + CW'(1);
      end
      if (cmd_i.push_start) begin
        visited_q[start_idx] <= 1'b1;
        on_path_q[start_idx] <= 1'b1;
        depth_q <= depth_q + CW'(1);
      end
      if (cmd_i.push_nbr) begin
        visited_q[cur_idx] <= 1'b1;
        on_path_q[cur_idx] <= 1'b1;
        depth_q <= depth_q + CW'(1);
      end
      if (cmd_i.pop) begin
        on_path_q[top_q] <= 1'b0;
        depth_q <= depth_q - CW'(1);
      end
      if (cmd_i.found) begin
        cycle_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        row_valid_q <= '0;
        bad_q       <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.edge_ok       = edge_present_i && in_range;
  assign sts_o.in_last       = last_edge_i;
  assign sts_o.last_q        = last_q;
  assign sts_o.start_done    = (start_q >= n_eff);
  assign sts_o.start_visited = visited_q[start_idx];
  assign sts_o.cur_done      = (cursor_q >= n_eff);
  assign sts_o.cur_edge      = row_q[cur_idx];
  assign sts_o.cur_on_path   = on_path_q[cur_idx];
  assign sts_o.cur_visited   = visited_q[cur_idx];
  assign sts_o.depth_one     = (depth_q == CW'(1));
  assign sts_o.out_busy      = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign has_cycle_o     = has_cycle_q;
  assign bad_edge_seen_o = bad_out_q;

endmodule

/* rtl/directed_cycle_detector.sv */
// ----------------------------------------------------------------------------
// directed_cycle_detector
// Loads a directed graph one edge per item and, on the last item, searches
// it depth first for a cycle and returns one result item.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  src_node_i dst_node_i edge_present_i last_edge_i
// out       output     out_valid_o/out_ready_i has_cycle_o bad_edge_seen_o
// cfg       input      APB psel/penable       paddr pwdata prdata, node_count at 0x0
//
// An item with a stored edge passes through the write-back state before the
// next item is taken, since the adjacency row is read, merged and written back.
// The search scans one neighbor per cycle in the step state while no push or
// pop comes between; each push first goes through the registered row read, and
// a pop to a lower path entry through the registered stack and row reads.
// Reset clears all row valid bits at once, so no clearing pass is needed.
// A waiting result is held in the output register while new items load;
// the next search only finishes once that result has been taken.
// ----------------------------------------------------------------------------
module directed_cycle_detector
  import dcd_pkg::*;
#(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [NODE_FIELD_W-1:0] src_node_i,
  input  logic [NODE_FIELD_W-1:0] dst_node_i,
  input  logic                    edge_present_i,
  input  logic                    last_edge_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    has_cycle_o,
  output logic                    bad_edge_seen_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  logic [NODE_COUNT_W-1:0] node_count_q;
  dcd_cmd_t                cmd;
  dcd_sts_t                sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_NODE_COUNT)) begin
      node_count_q <= pwdata[NODE_COUNT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      REG_NODE_COUNT: prdata = {{(PDATA_W - NODE_COUNT_W){1'b0}}, node_count_q};
      default:        prdata = '0;
    endcase
  end

  dcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dcd_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .node_count_i    (node_count_q),
    .src_node_i      (src_node_i),
    .dst_node_i      (dst_node_i),
    .edge_present_i  (edge_present_i),
    .last_edge_i     (last_edge_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .has_cycle_o     (has_cycle_o),
    .bad_edge_seen_o (bad_edge_seen_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

/* dv/tb_directed_cycle_detector.sv */
// ----------------------------------------------------------------------------
// tb_directed_cycle_detector
// Self-checking testbench of the directed cycle detector. Graphs are streamed
// in as edge items under random gaps and back-pressure. A predictor in the
// testbench keeps its own adjacency matrix and runs its own depth-first
// search, and every result item is checked against its verdict. The node
// count register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_directed_cycle_detector;
  import dcd_pkg::*;

  localparam int unsigned NODES = 64;
  localparam int unsigned LONG_HOLD = 2000;
  localparam int unsigned PRESSURE_PHASE = 4;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] src;
    logic [NODE_FIELD_W-1:0] dst;
    logic                    present;
    logic                    last;
  } edge_item_t;

  typedef struct packed {
    logic has_cycle;
    logic bad_edge;
  } verdict_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [NODE_FIELD_W-1:0] src_node_i = '0;
  logic [NODE_FIELD_W-1:0] dst_node_i = '0;
  logic                    edge_present_i = 1'b0;
  logic                    last_edge_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    has_cycle_o;
  logic                    bad_edge_seen_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [PDATA_W-1:0]      pwdata = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  directed_cycle_detector #(
    .MAX_NODES(NODES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .src_node_i     (src_node_i),
    .dst_node_i     (dst_node_i),
    .edge_present_i (edge_present_i),
    .last_edge_i    (last_edge_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .has_cycle_o    (has_cycle_o),
    .bad_edge_seen_o(bad_edge_seen_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  edge_item_t              pending_edges[$];
  verdict_t                expected_verdicts[$];
  logic [NODES-1:0]        model_rows [NODES];
  logic                    model_bad_edge = 1'b0;
  logic [NODE_COUNT_W-1:0] model_node_count = NODE_COUNT_RESET;
  int unsigned             error_count = 0;
  int unsigned             results_seen = 0;
  int unsigned             queued_count = 0;
  logic                    hold_armed = 1'b0;
  logic                    hold_done = 1'b0;

  initial begin
    foreach (model_rows[r]) model_rows[r] = '0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR at %0t, result %0d: %s, got %0d, expected %0d",
             $realtime, results_seen, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned active_nodes(input logic [NODE_COUNT_W-1:0] cnt);
    return (cnt > NODES) ? NODES : int'(cnt);
  endfunction

  // Iterative depth-first search over nodes below n, one neighbor per step.
  function automatic logic graph_has_cycle(input int unsigned n);
    logic [NODES-1:0] seen;
    logic [NODES-1:0] on_path;
    int unsigned      path [NODES];
    int unsigned      cursor [NODES];
    int unsigned      depth;
    int unsigned      top;
    int unsigned      c;
    seen = '0;
    on_path = '0;
    depth = 0;
    for (int unsigned s = 0; s < n; s++) begin
      if (seen[s]) continue;
      seen[s] = 1'b1;
      on_path[s] = 1'b1;
      path[0] = s;
      cursor[0] = 0;
      depth = 1;
      while (depth > 0) begin
        top = path[depth-1];
        c = cursor[depth-1];
        if (c >= n) begin
          on_path[top] = 1'b0;
          depth--;
          continue;
        end
        cursor[depth-1] = c + 1;
        if (!model_rows[top][c]) continue;
        if (on_path[c]) return 1'b1;
        if (!seen[c]) begin
          seen[c] = 1'b1;
          on_path[c] = 1'b1;
          path[depth] = c;
          cursor[depth] = 0;
          depth++;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic apply_item(input edge_item_t it);
    int unsigned n;
    verdict_t    v;
    n = active_nodes(model_node_count);
    if (it.present) begin
      if (it.src < n && it.dst < n) model_rows[it.src][it.dst] = 1'b1;
      else model_bad_edge = 1'b1;
    end
    if (it.last) begin
      v.has_cycle = graph_has_cycle(n);
      v.bad_edge = model_bad_edge;
      expected_verdicts = {expected_verdicts, v};
      foreach (model_rows[r]) model_rows[r] = '0;
      model_bad_edge = 1'b0;
    end
  endtask

  // Sender: offers queued items with random gaps and holds each until taken.
  int unsigned send_gap = 0;
  logic        send_calm = 1'b0;
  edge_item_t  held_item;

  always @(posedge clk_i) begin : drive_edges
    logic offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        apply_item(held_item);
        offer = 1'b0;
        if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 12);
      end
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_edges.size() != 0) begin
          held_item = pending_edges.pop_front();
          src_node_i <= held_item.src;
          dst_node_i <= held_item.dst;
          edge_present_i <= held_item.present;
          last_edge_i <= held_item.last;
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
    end
  end

  // Receiver: stalls a random count after each item, once for a long stretch.
  int unsigned sink_wait = 0;
  logic        sink_calm = 1'b0;

  always @(posedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (hold_armed && !hold_done) begin
          sink_wait = LONG_HOLD;
          hold_done <= 1'b1;
        end else begin
          if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
          sink_wait = sink_calm ? 0 : $urandom_range(0, 12);
        end
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      out_ready_i <= (sink_wait == 0);
    end
  end

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with no graph pending", has_cycle_o, 0);
      end else begin
        want = expected_verdicts.pop_front();
        if (has_cycle_o !== want.has_cycle)
          report_mismatch("has_cycle", has_cycle_o, want.has_cycle);
        if (bad_edge_seen_o !== want.bad_edge)
          report_mismatch("bad_edge_seen", bad_edge_seen_o, want.bad_edge);
      end
    end
  end

  task automatic queue_item(input int unsigned s, input int unsigned d,
                            input bit p, input bit l);
    edge_item_t it;
    it.src = s[NODE_FIELD_W-1:0];
    it.dst = d[NODE_FIELD_W-1:0];
    it.present = p;
    it.last = l;
    pending_edges = {pending_edges, it};
    if (p || l) queued_count++;
  endtask

  task automatic write_node_count(input logic [NODE_COUNT_W-1:0] value);
    logic [PDATA_W-1:0] word;
    word = $urandom();
    word[NODE_COUNT_W-1:0] = value;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_NODE_COUNT;
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    model_node_count = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== PDATA_W'(value)) report_mismatch("node_count readback", prdata, value);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (pending_edges.size() != 0 || in_valid_i || expected_verdicts.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  // Queues one graph for n active nodes, closed by a last item if asked.
  task automatic queue_graph(input int unsigned n, input bit close);
    int unsigned k;
    int unsigned a;
    int unsigned b;
    int unsigned t;
    int unsigned mode;
    bit          acyclic;
    k = $urandom_range(0, (n > 7) ? 24 : 3 * n + 2);
    acyclic = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i < k + 1; i++) begin
      mode = $urandom_range(0, 19);
      a = (n > 0) ? $urandom_range(0, n - 1) : 0;
      b = (n > 0) ? $urandom_range(0, n - 1) : 0;
      if (i == k && !close) break;
      if (i == k && mode >= 10) begin
        queue_item($urandom_range(0, 63), $urandom_range(0, 63), 1'b0, 1'b1);
        break;
      end
      if (n < NODES && (n == 0 || mode == 0)) begin
        t = $urandom_range(0, 2);
        if (t != 1) a = $urandom_range(n, 63);
        if (t != 0) b = $urandom_range(n, 63);
      end else if (mode == 1 && i < k) begin
        queue_item($urandom_range(0, 63), $urandom_range(0, 63), 1'b0, 1'b0);
        continue;
      end else if (mode == 2 && i < k) begin
        // The reverse edge follows, closing a two-node loop, or a self-loop if a equals b.
        queue_item(a, b, 1'b1, 1'b0);
        t = a;
        a = b;
        b = t;
      end else if (acyclic) begin
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        if (a == b && n > 1) begin
          if (b == n - 1) a = a - 1;
          else b = b + 1;
        end
      end
      queue_item(a, b, 1'b1, i == k);
    end
  endtask

  initial begin : stimulus
    logic [NODE_COUNT_W-1:0] phase_counts [10];
    int unsigned             start_count;
    phase_counts = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd8, 7'd65, 7'd16, 7'd0, 7'd64, 7'd3};
    phase_counts[7] = 7'($urandom_range(0, 127));
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset node count: empty graph, self-loop on the last item, a triangle,
    // then a chain with a duplicate and an ignored item.
    queue_item(0, 0, 1'b0, 1'b1);
    queue_item(63, 63, 1'b1, 1'b1);
    queue_item(0, 1, 1'b1, 1'b0);
    queue_item(1, 2, 1'b1, 1'b0);
    queue_item(2, 0, 1'b1, 1'b0);
    queue_item(45, 18, 1'b0, 1'b1);
    queue_item(0, 1, 1'b1, 1'b0);
    queue_item(1, 2, 1'b1, 1'b0);
    queue_item(2, 3, 1'b1, 1'b0);
    queue_item(1, 2, 1'b1, 1'b0);
    queue_item(21, 42, 1'b0, 1'b0);
    queue_item(3, 63, 1'b1, 1'b1);
    wait_until_drained();

    write_node_count(7'd0);
    queue_item(0, 0, 1'b1, 1'b1);
    queue_item(63, 63, 1'b0, 1'b1);
    wait_until_drained();

    write_node_count(7'd127);
    queue_item(63, 62, 1'b1, 1'b0);
    queue_item(62, 63, 1'b1, 1'b1);
    wait_until_drained();

    write_node_count(7'd5);
    queue_item(5, 0, 1'b1, 1'b0);
    queue_item(0, 4, 1'b1, 1'b0);
    queue_item(4, 0, 1'b1, 1'b1);
    wait_until_drained();

    // A loop among high nodes is loaded, then the count is lowered below it.
    write_node_count(7'd16);
    queue_item(10, 12, 1'b1, 1'b0);
    queue_item(12, 10, 1'b1, 1'b0);
    queue_item(1, 2, 1'b1, 1'b0);
    wait_until_drained();
    write_node_count(7'd8);
    queue_item(3, 4, 1'b1, 1'b1);
    wait_until_drained();

    for (int unsigned p = 0; p < 10; p++) begin
      write_node_count(phase_counts[p]);
      @(negedge clk_i);
      if (p == PRESSURE_PHASE) hold_armed <= 1'b1;
      start_count = queued_count;
      while (queued_count - start_count < 100) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_item($urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          queue_graph(active_nodes(phase_counts[p]), 1'b1);
        end
      end
      if (p != 9 && $urandom_range(0, 2) == 0)
        queue_graph(active_nodes(phase_counts[p]), 1'b0);
      wait_until_drained();
    end

    repeat (100) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #300_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/dcd_pkg.sv
rtl/dcd_ram.sv
rtl/dcd_ctrl.sv
rtl/dcd_datapath.sv
rtl/directed_cycle_detector.sv
dv/tb_directed_cycle_detector.sv
